FILE: hw/rtl/spi_nor_flash_sequencer_macros.svh
// Assertion macros for the SPI NOR flash sequencer checker.
// Included by the checker file only; no other dependencies.
`ifndef SPI_NOR_FLASH_SEQUENCER_MACROS_SVH
`define SPI_NOR_FLASH_SEQUENCER_MACROS_SVH

// same-cycle implication, quiet during reset
`define SFS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfs check failed");

// next-cycle implication, also checked across reset
`define SFS_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sfs check failed");

`endif

FILE: hw/rtl/sfs_pkg.sv
// Shared types, codes and constants of the SPI NOR flash sequencer.
// No dependencies; imported by the sequencer, step unit, result queue and checker.
package sfs_pkg;

   localparam int unsigned PageSizeDefault = 256;  // power of two, 16 to 4096

   localparam int unsigned RSP_DEPTH = 4;

   // request / item codes
   localparam logic [2:0] CMD_READ   = 3'd0;
   localparam logic [2:0] CMD_WRITE  = 3'd1;
   localparam logic [2:0] CMD_SECTOR = 3'd2;
   localparam logic [2:0] CMD_CHIP   = 3'd3;
   localparam logic [2:0] CMD_ID     = 3'd4;
   localparam logic [2:0] CMD_RET    = 3'd5;
   localparam logic [2:0] CMD_WDATA  = 3'd6;
   localparam logic [2:0] CMD_TICK   = 3'd7;

   // result kinds
   localparam logic [2:0] KIND_SEND    = 3'd0;
   localparam logic [2:0] KIND_RELEASE = 3'd1;
   localparam logic [2:0] KIND_RDATA   = 3'd2;
   localparam logic [2:0] KIND_WANT    = 3'd3;
   localparam logic [2:0] KIND_DONE    = 3'd4;

   // done status
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ERROR   = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;

   // flash opcodes
   localparam logic [7:0] OPC_READ_ID = 8'h90;
   localparam logic [7:0] OPC_RDSR    = 8'h05;
   localparam logic [7:0] OPC_WREN    = 8'h06;
   localparam logic [7:0] OPC_SE      = 8'h20;
   localparam logic [7:0] OPC_CE      = 8'hC7;
   localparam logic [7:0] OPC_PP      = 8'h02;
   localparam logic [7:0] OPC_READ    = 8'h03;
   localparam logic [7:0] OPC_DUMMY   = 8'h00;

   localparam int unsigned SR_BUSY_BIT = 0;
   localparam int unsigned SR_WEL_BIT  = 1;

   localparam logic [7:0] MAKER_A = 8'hEF;
   localparam logic [7:0] MAKER_B = 8'hC8;

   // register indexes
   localparam logic [2:0] CSR_ADDR_LIMIT  = 3'd0;
   localparam logic [2:0] CSR_WEL_POLLS   = 3'd1;
   localparam logic [2:0] CSR_WREN_TRIES  = 3'd2;
   localparam logic [2:0] CSR_PROG_TMO    = 3'd3;
   localparam logic [2:0] CSR_SECTOR_TMO  = 3'd4;
   localparam logic [2:0] CSR_CHIP_TMO    = 3'd5;
   localparam logic [2:0] CSR_SECTOR_MIN  = 3'd6;

   typedef enum logic [4:0] {
      PH_IDLE, PH_OP_SENT, PH_ADDR_H, PH_ADDR_M, PH_ADDR_L, PH_READ_DATA,
      PH_WANT_DATA, PH_DATA_SENT, PH_WREN_SENT, PH_WEL_CMD, PH_WEL_STAT,
      PH_RETRY_WAIT, PH_BUSY_WAIT, PH_BUSY_CMD, PH_BUSY_STAT, PH_SETTLE, PH_ID
   } phase_type;

   typedef struct packed {
      logic [24:0] addr_limit;
      logic [7:0]  wel_poll_limit;
      logic [5:0]  wren_retries;
      logic [15:0] program_timeout_ms;
      logic [15:0] sector_timeout_ms;
      logic [15:0] chip_timeout_ms;
      logic [15:0] sector_min_ms;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [23:0] address;
      logic [24:0] length;
      logic [7:0]  byte_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  out_byte;
      logic [1:0]  status;
      logic [24:0] byte_count;
      logic [15:0] device_id;
      logic        last;
   } rsp_type;

   function automatic rsp_type mk_rsp(logic [2:0] kind, logic [7:0] b, logic [1:0] st,
                                      logic [24:0] cnt, logic [15:0] id);
      rsp_type r;
      r.kind       = kind;
      r.out_byte   = b;
      r.status     = st;
      r.byte_count = cnt;
      r.device_id  = id;
      r.last       = 1'b0;
      return r;
   endfunction

endpackage

FILE: hw/rtl/sfs_req_if.sv
// Request channel of the SPI NOR flash sequencer: valid/ready plus one item.
// Depends on nothing.
interface sfs_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [23:0] address;
   logic [24:0] length;
   logic [7:0]  byte_value;

   modport source (output valid, cmd, address, length, byte_value, input ready);
   modport sink   (input valid, cmd, address, length, byte_value, output ready);
endinterface

FILE: hw/rtl/sfs_rsp_if.sv
// Result channel of the SPI NOR flash sequencer: valid/ready plus one result.
// Depends on nothing.
interface sfs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  out_byte;
   logic [1:0]  status;
   logic [24:0] byte_count;
   logic [15:0] device_id;
   logic        last;

   modport source (output valid, kind, out_byte, status, byte_count, device_id, last,
                   input ready);
   modport sink   (input valid, kind, out_byte, status, byte_count, device_id, last,
                   output ready);
endinterface

FILE: hw/rtl/spi_nor_flash_sequencer.sv
// SPI NOR flash sequencer. One request, SPI return byte, write-data byte or
// millisecond tick is taken per beat on req_bus; each beat runs one step of
// the sequencer when the queue has room and queues zero to three results
// (bytes to send, chip-select release, read data, write-data request, done)
// in a four-entry queue that rsp_bus drains one result per cycle while ready
// is high. The input takes a beat every cycle while the queue holds at most
// one result, so the sustained rate is one beat per cycle, bounded by one
// result per cycle on the output. PAGE_BYTES must be a power of two.
// Depends on sfs_pkg, sfs_req_if, sfs_rsp_if, sfs_step_unit, sfs_rsp_queue.
module spi_nor_flash_sequencer #(
   parameter int unsigned PAGE_BYTES = sfs_pkg::PageSizeDefault
) (
   input  logic        clock,
   input  logic        reset,
   sfs_req_if.sink     req_bus,
   sfs_rsp_if.source   rsp_bus,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [24:0] csr_wdata
);
   import sfs_pkg::*;

   cfg_type    cfg_ff;
   req_type    item;
   logic       room;
   logic [1:0] push_n;
   rsp_type    push_data [3];
   rsp_type    out_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.addr_limit         <= 25'd1048576;
         cfg_ff.wel_poll_limit     <= 8'd99;
         cfg_ff.wren_retries       <= 6'd49;
         cfg_ff.program_timeout_ms <= 16'd49;
         cfg_ff.sector_timeout_ms  <= 16'd399;
         cfg_ff.chip_timeout_ms    <= 16'd39999;
         cfg_ff.sector_min_ms      <= 16'd60;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ADDR_LIMIT: cfg_ff.addr_limit         <= csr_wdata;
            CSR_WEL_POLLS:  cfg_ff.wel_poll_limit     <= csr_wdata[7:0];
            CSR_WREN_TRIES: cfg_ff.wren_retries       <= csr_wdata[5:0];
            CSR_PROG_TMO:   cfg_ff.program_timeout_ms <= csr_wdata[15:0];
            CSR_SECTOR_TMO: cfg_ff.sector_timeout_ms  <= csr_wdata[15:0];
            CSR_CHIP_TMO:   cfg_ff.chip_timeout_ms    <= csr_wdata[15:0];
            CSR_SECTOR_MIN: cfg_ff.sector_min_ms      <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign item.cmd        = req_bus.cmd;
   assign item.address    = req_bus.address;
   assign item.length     = req_bus.length;
   assign item.byte_value = req_bus.byte_value;

   sfs_step_unit #(.PAGE_BYTES(PAGE_BYTES)) u_step (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (req_bus.valid),
      .item       (item),
      .item_ready (req_bus.ready),
      .room       (room),
      .push_n     (push_n),
      .push_data  (push_data)
   );

   sfs_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push_data (push_data),
      .room      (room),
      .out_valid (rsp_bus.valid),
      .out_data  (out_data),
      .out_ready (rsp_bus.ready)
   );

   assign rsp_bus.kind       = out_data.kind;
   assign rsp_bus.out_byte   = out_data.out_byte;
   assign rsp_bus.status     = out_data.status;
   assign rsp_bus.byte_count = out_data.byte_count;
   assign rsp_bus.device_id  = out_data.device_id;
   assign rsp_bus.last       = out_data.last;
endmodule

FILE: hw/rtl/sfs_rsp_queue.sv
// Four-entry queue: up to three results in per cycle, one out when ready.
// Depends on sfs_pkg.
module sfs_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_n,
   input  sfs_pkg::rsp_type push_data [3],
   output logic             room,
   output logic             out_valid,
   output sfs_pkg::rsp_type out_data,
   input  logic             out_ready
);
   import sfs_pkg::*;

   localparam int unsigned PW = $clog2(RSP_DEPTH);

   rsp_type         entry_ff [RSP_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     count_ff, count_in;
   logic            pop;

   // space for a full three-result beat
   assign room      = count_ff <= (PW+1)'(RSP_DEPTH - 3);
   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(push_n);
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      count_in  = count_ff + (PW+1)'(push_n) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload store
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < push_n) begin
            entry_ff[wr_ptr_ff + PW'(i)] <= push_data[i];
         end
      end
   end
endmodule

FILE: hw/rtl/sfs_step_unit.sv
// Sequencer state and per-item step logic; registers one item, runs it once.
// Depends on sfs_pkg.
module sfs_step_unit #(
   parameter int unsigned PAGE_BYTES = sfs_pkg::PageSizeDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  sfs_pkg::cfg_type cfg,
   input  logic             item_valid,
   input  sfs_pkg::req_type item,
   output logic             item_ready,
   input  logic             room,
   output logic [1:0]       push_n,
   output sfs_pkg::rsp_type push_data [3]
);
   import sfs_pkg::*;

   localparam int unsigned PB = $clog2(PAGE_BYTES);
   localparam int unsigned CW = PB + 1;

   logic        item_vld_ff;
   req_type     item_ff;
   logic        take;

   phase_type   phase_ff, phase_in;
   logic [2:0]  operation_ff, operation_in;
   logic [23:0] cur_address_ff, cur_address_in;
   logic [24:0] bytes_left_ff, bytes_left_in;
   logic [CW-1:0] chunk_left_ff, chunk_left_in;
   logic [24:0] bytes_done_ff, bytes_done_in;
   logic [15:0] ms_elapsed_ff, ms_elapsed_in;
   logic [7:0]  poll_count_ff, poll_count_in;
   logic [5:0]  retry_count_ff, retry_count_in;
   logic [15:0] id_value_ff, id_value_in;

   rsp_type     res [3];
   logic [1:0]  n;
   logic [24:0] span;
   logic [15:0] busy_limit;
   logic        ret, tick;
   logic [7:0]  bv;

   // bytes up to the next page boundary, capped by what is left
   function automatic logic [CW-1:0] chunk_len(logic [23:0] addr, logic [24:0] left);
      logic [CW-1:0] rm;
      rm = CW'(PAGE_BYTES) - CW'(addr[PB-1:0]);
      return (25'(rm) < left) ? rm : CW'(left);
   endfunction

   // input register
   assign take       = item_vld_ff && room;
   assign item_ready = !item_vld_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else if (item_ready) begin
         item_vld_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (item_ready && item_valid) begin
         item_ff <= item;
      end
   end

   assign ret  = item_ff.cmd == CMD_RET;
   assign tick = item_ff.cmd == CMD_TICK;
   assign bv   = item_ff.byte_value;
   assign span = cfg.addr_limit - 25'(item_ff.address);

   always_comb begin
      case (operation_ff)
         CMD_WRITE:  busy_limit = cfg.program_timeout_ms;
         CMD_SECTOR: busy_limit = cfg.sector_timeout_ms;
         default:    busy_limit = cfg.chip_timeout_ms;
      endcase
   end

   // one step of the sequencer
   always_comb begin
      phase_in       = phase_ff;
      operation_in   = operation_ff;
      cur_address_in = cur_address_ff;
      bytes_left_in  = bytes_left_ff;
      chunk_left_in  = chunk_left_ff;
      bytes_done_in  = bytes_done_ff;
      ms_elapsed_in  = ms_elapsed_ff;
      poll_count_in  = poll_count_ff;
      retry_count_in = retry_count_ff;
      id_value_in    = id_value_ff;
      for (int i = 0; i < 3; i++) res[i] = '0;
      n = 2'd0;
      if (take) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (item_ff.cmd <= CMD_ID) begin
                  operation_in   = item_ff.cmd;
                  cur_address_in = item_ff.address;
                  bytes_done_in  = '0;
                  case (item_ff.cmd) inside
                     CMD_READ, CMD_WRITE: begin
                        if (25'(item_ff.address) > cfg.addr_limit) begin
                           res[n] = mk_rsp(KIND_DONE, '0, ST_OK, '0, '0); n = n + 2'd1;
                           phase_in = PH_IDLE;
                        end else begin
                           bytes_left_in = (span < item_ff.length) ? span : item_ff.length;
                           if (item_ff.cmd == CMD_READ) begin
                              res[n] = mk_rsp(KIND_SEND, OPC_READ, ST_OK, '0, '0);
                              n = n + 2'd1;
                              phase_in = PH_OP_SENT;
                           end else if (bytes_left_in == '0) begin
                              res[n] = mk_rsp(KIND_DONE, '0, ST_OK, '0, '0); n = n + 2'd1;
                              phase_in = PH_IDLE;
                           end else begin
                              chunk_left_in  = chunk_len(item_ff.address, bytes_left_in);
                              retry_count_in = '0;
                              poll_count_in  = '0;
                              res[n] = mk_rsp(KIND_SEND, OPC_WREN, ST_OK, '0, '0);
                              n = n + 2'd1;
                              phase_in = PH_WREN_SENT;
                           end
                        end
                     end
                     CMD_SECTOR, CMD_CHIP: begin
                        retry_count_in = '0;
                        poll_count_in  = '0;
                        res[n] = mk_rsp(KIND_SEND, OPC_WREN, ST_OK, '0, '0); n = n + 2'd1;
                        phase_in = PH_WREN_SENT;
                     end
                     default: begin
                        id_value_in   = '0;
                        poll_count_in = '0;
                        res[n] = mk_rsp(KIND_SEND, OPC_READ_ID, ST_OK, '0, '0);
                        n = n + 2'd1;
                        phase_in = PH_ID;
                     end
                  endcase
               end
            end
            PH_OP_SENT: begin
               if (ret) begin
                  res[n] = mk_rsp(KIND_SEND, cur_address_ff[23:16], ST_OK, '0, '0);
                  n = n + 2'd1;
                  phase_in = PH_ADDR_H;
               end
            end
            PH_ADDR_H: begin
               if (ret) begin
                  res[n] = mk_rsp(KIND_SEND, cur_address_ff[15:8], ST_OK, '0, '0);
                  n = n + 2'd1;
                  phase_in = PH_ADDR_M;
               end
            end
            PH_ADDR_M: begin
               if (ret) begin
                  res[n] = mk_rsp(KIND_SEND, cur_address_ff[7:0], ST_OK, '0, '0);
                  n = n + 2'd1;
                  phase_in = PH_ADDR_L;
               end
            end
            PH_ADDR_L: begin
               if (ret) begin
                  if (operation_ff == CMD_READ) begin
                     if (bytes_left_ff != '0) begin
                        res[n] = mk_rsp(KIND_SEND, OPC_DUMMY, ST_OK, '0, '0); n = n + 2'd1;
                        phase_in = PH_READ_DATA;
                     end else begin
                        res[n] = mk_rsp(KIND_RELEASE, '0, ST_OK, '0, '0); n = n + 2'd1;
                        res[n] = mk_rsp(KIND_DONE, '0, ST_OK, '0, '0); n = n + 2'd1;
                        phase_in = PH_IDLE;
                     end
                  end else if (operation_ff == CMD_WRITE) begin
                     res[n] = mk_rsp(KIND_WANT, '0, ST_OK, '0, '0); n = n + 2'd1;
                     phase_in = PH_WANT_DATA;
                  end else begin
                     res[n] = mk_rsp(KIND_RELEASE, '0, ST_OK, '0, '0); n = n + 2'd1;
                     ms_elapsed_in = '0;
                     phase_in = PH_BUSY_WAIT;
                  end
               end
            end
            PH_READ_DATA: begin
               if (ret) begin
                  res[n] = mk_rsp(KIND_RDATA, bv, ST_OK, '0, '0); n = n + 2'd1;
                  bytes_done_in = bytes_done_ff + 25'd1;
                  bytes_left_in = bytes_left_ff - 25'd1;
                  if (bytes_left_in != '0) begin
                     res[n] = mk_rsp(KIND_SEND, OPC_DUMMY, ST_OK, '0, '0); n = n + 2'd1;
                  end else begin
                     res[n] = mk_rsp(KIND_RELEASE, '0, ST_OK, '0, '0); n = n + 2'd1;
                     res[n] = mk_rsp(KIND_DONE, '0, ST_OK, bytes_done_in, '0);
                     n = n + 2'd1;
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_WANT_DATA: begin
               if (item_ff.cmd == CMD_WDATA) begin
                  res[n] = mk_rsp(KIND_SEND, bv, ST_OK, '0, '0); n = n + 2'd1;
                  phase_in = PH_DATA_SENT;
               end
            end
            PH_DATA_SENT: begin
               if (ret) begin
                  cur_address_in = cur_address_ff + 24'd1;
                  bytes_left_in  = bytes_left_ff - 25'd1;
                  bytes_done_in  = bytes_done_ff + 25'd1;
                  if (chunk_left_ff != '0) chunk_left_in = chunk_left_ff - CW'(1);
                  if (chunk_left_in != '0 && bytes_left_in != '0) begin
                     res[n] = mk_rsp(KIND_WANT, '0, ST_OK, '0, '0); n = n + 2'd1;
                     phase_in = PH_WANT_DATA;
                  end else begin
                     res[n] = mk_rsp(KIND_RELEASE, '0, ST_OK, '0, '0); n = n + 2'd1;
                     ms_elapsed_in = '0;
                     phase_in = PH_BUSY_WAIT;
                  end
               end
            end
            PH_WREN_SENT: begin
               if (ret) begin
                  res[n] = mk_rsp(KIND_RELEASE, '0, ST_OK, '0, '0); n = n + 2'd1;
                  res[n] = mk_rsp(KIND_SEND, OPC_RDSR, ST_OK, '0, '0); n = n + 2'd1;
                  phase_in = PH_WEL_CMD;
               end
            end
            PH_WEL_CMD: begin
               if (ret) begin
                  res[n] = mk_rsp(KIND_SEND, OPC_DUMMY, ST_OK, '0, '0); n = n + 2'd1;
                  phase_in = PH_WEL_STAT;
               end
            end
            PH_WEL_STAT: begin
               if (ret) begin
                  res[n] = mk_rsp(KIND_RELEASE, '0, ST_OK, '0, '0); n = n + 2'd1;
                  if (bv[SR_WEL_BIT]) begin
                     if (operation_ff == CMD_WRITE) begin
                        res[n] = mk_rsp(KIND_SEND, OPC_PP, ST_OK, '0, '0); n = n + 2'd1;
                        phase_in = PH_OP_SENT;
                     end else if (operation_ff == CMD_SECTOR) begin
                        res[n] = mk_rsp(KIND_SEND, OPC_SE, ST_OK, '0, '0); n = n + 2'd1;
                        phase_in = PH_OP_SENT;
                     end else begin
                        res[n] = mk_rsp(KIND_SEND, OPC_CE, ST_OK, '0, '0); n = n + 2'd1;
                        phase_in = PH_ADDR_L;
                     end
                  end else if ({1'b0, poll_count_ff} + 9'd1 >= {1'b0, cfg.wel_poll_limit})
                  begin
                     if (operation_ff == CMD_WRITE) begin
                        retry_count_in = retry_count_ff + 6'd1;
                        if (retry_count_in >= cfg.wren_retries) begin
                           res[n] = mk_rsp(KIND_DONE, '0, ST_ERROR, '0, '0); n = n + 2'd1;
                           phase_in = PH_IDLE;
                        end else begin
                           phase_in = PH_RETRY_WAIT;
                        end
                     end else begin
                        res[n] = mk_rsp(KIND_DONE, '0, ST_ERROR, '0, '0); n = n + 2'd1;
                        phase_in = PH_IDLE;
                     end
                  end else begin
                     poll_count_in = poll_count_ff + 8'd1;
                     res[n] = mk_rsp(KIND_SEND, OPC_RDSR, ST_OK, '0, '0); n = n + 2'd1;
                     phase_in = PH_WEL_CMD;
                  end
               end
            end
            PH_RETRY_WAIT: begin
               if (tick) begin
                  poll_count_in = '0;
                  res[n] = mk_rsp(KIND_SEND, OPC_WREN, ST_OK, '0, '0); n = n + 2'd1;
                  phase_in = PH_WREN_SENT;
               end
            end
            PH_BUSY_WAIT: begin
               if (tick) begin
                  if (ms_elapsed_ff != 16'hFFFF) ms_elapsed_in = ms_elapsed_ff + 16'd1;
                  res[n] = mk_rsp(KIND_SEND, OPC_RDSR, ST_OK, '0, '0); n = n + 2'd1;
                  phase_in = PH_BUSY_CMD;
               end
            end
            PH_BUSY_CMD: begin
               if (ret) begin
                  res[n] = mk_rsp(KIND_SEND, OPC_DUMMY, ST_OK, '0, '0); n = n + 2'd1;
                  phase_in = PH_BUSY_STAT;
               end
            end
            PH_BUSY_STAT: begin
               if (ret) begin
                  res[n] = mk_rsp(KIND_RELEASE, '0, ST_OK, '0, '0); n = n + 2'd1;
                  if (bv[SR_BUSY_BIT]) begin
                     if (ms_elapsed_ff >= busy_limit) begin
                        res[n] = mk_rsp(KIND_DONE, '0, ST_TIMEOUT, '0, '0); n = n + 2'd1;
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in = PH_BUSY_WAIT;
                     end
                  end else if (operation_ff == CMD_WRITE) begin
                     if (bytes_left_ff == '0) begin
                        res[n] = mk_rsp(KIND_DONE, '0, ST_OK, bytes_done_ff, '0);
                        n = n + 2'd1;
                        phase_in = PH_IDLE;
                     end else begin
                        chunk_left_in  = chunk_len(cur_address_ff, bytes_left_ff);
                        retry_count_in = '0;
                        poll_count_in  = '0;
                        res[n] = mk_rsp(KIND_SEND, OPC_WREN, ST_OK, '0, '0); n = n + 2'd1;
                        phase_in = PH_WREN_SENT;
                     end
                  end else if (operation_ff == CMD_SECTOR && ms_elapsed_ff < cfg.sector_min_ms)
                  begin
                     phase_in = PH_SETTLE;
                  end else begin
                     res[n] = mk_rsp(KIND_DONE, '0, ST_OK, '0, '0); n = n + 2'd1;
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_SETTLE: begin
               if (tick) begin
                  if (ms_elapsed_ff != 16'hFFFF) ms_elapsed_in = ms_elapsed_ff + 16'd1;
                  if (ms_elapsed_in >= cfg.sector_min_ms) begin
                     res[n] = mk_rsp(KIND_DONE, '0, ST_OK, '0, '0); n = n + 2'd1;
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_ID: begin
               if (ret) begin
                  poll_count_in = poll_count_ff + 8'd1;
                  if (poll_count_in == 8'd5) id_value_in = {bv, 8'h00};
                  if (poll_count_in >= 8'd6) begin
                     id_value_in = {id_value_ff[15:8], bv};
                     res[n] = mk_rsp(KIND_RELEASE, '0, ST_OK, '0, '0); n = n + 2'd1;
                     res[n] = mk_rsp(KIND_DONE, '0,
                                     (id_value_in[15:8] == MAKER_A ||
                                      id_value_in[15:8] == MAKER_B) ? ST_OK : ST_ERROR,
                                     '0, id_value_in);
                     n = n + 2'd1;
                     phase_in = PH_IDLE;
                  end else begin
                     res[n] = mk_rsp(KIND_SEND, OPC_DUMMY, ST_OK, '0, '0); n = n + 2'd1;
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
      // flag the final result of this beat
      if (n != 2'd0) res[n - 2'd1].last = 1'b1;
   end

   assign push_n    = n;
   assign push_data = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         operation_ff   <= '0;
         cur_address_ff <= '0;
         bytes_left_ff  <= '0;
         chunk_left_ff  <= '0;
         bytes_done_ff  <= '0;
         ms_elapsed_ff  <= '0;
         poll_count_ff  <= '0;
         retry_count_ff <= '0;
         id_value_ff    <= '0;
      end else begin
         phase_ff       <= phase_in;
         operation_ff   <= operation_in;
         cur_address_ff <= cur_address_in;
         bytes_left_ff  <= bytes_left_in;
         chunk_left_ff  <= chunk_left_in;
         bytes_done_ff  <= bytes_done_in;
         ms_elapsed_ff  <= ms_elapsed_in;
         poll_count_ff  <= poll_count_in;
         retry_count_ff <= retry_count_in;
         id_value_ff    <= id_value_in;
      end
   end
endmodule

FILE: hw/rtl/sfs_checker.sv
// Port-level checks of the SPI NOR flash sequencer, bound to the top level.
// Depends on sfs_pkg and spi_nor_flash_sequencer_macros.svh.
`include "spi_nor_flash_sequencer_macros.svh"

module sfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [7:0]  rsp_out_byte,
   input logic [1:0]  rsp_status,
   input logic [24:0] rsp_byte_count,
   input logic [15:0] rsp_device_id,
   input logic        rsp_last
);
   import sfs_pkg::*;

   // a stalled result beat holds its kind, byte and last flag
   `SFS_ASSERT_IMPL(a_rsp_hold, clock, reset, $past(rsp_valid && !rsp_ready) && !$past(reset), rsp_valid && $stable(rsp_kind) && $stable(rsp_out_byte) && $stable(rsp_last))
   // done always closes the results of its beat
   `SFS_ASSERT_IMPL(a_done_last, clock, reset, rsp_valid && rsp_kind == KIND_DONE, rsp_last)
   // only done carries status, count and id
   `SFS_ASSERT_IMPL(a_side_zero, clock, reset, rsp_valid && rsp_kind != KIND_DONE, rsp_status == ST_OK && rsp_byte_count == '0 && rsp_device_id == '0)
   // reset leaves nothing to deliver
   `SFS_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid)
endmodule

bind spi_nor_flash_sequencer sfs_checker u_sfs_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_kind       (rsp_bus.kind),
   .rsp_out_byte   (rsp_bus.out_byte),
   .rsp_status     (rsp_bus.status),
   .rsp_byte_count (rsp_bus.byte_count),
   .rsp_device_id  (rsp_bus.device_id),
   .rsp_last       (rsp_bus.last)
);
